>>> sv/rstba_pkg.sv
// Shared types and constants for the risk-set tally by arm.
// Used by the controller, the datapath and the top level; depends on nothing.
package rstba_pkg;

    // Number of arms that are counted; arms at or above this are ignored.
    localparam int ARMS = 4;
    localparam int ARM_IDX_W = (ARMS > 1) ? $clog2(ARMS) : 1;

    // Field widths.
    localparam int TIME_W = 32;
    localparam int EVCNT_W = 8;
    localparam int ARM_W = 4;
    localparam int SLOT_W = 16;
    localparam int AT_RISK_W = 24;
    localparam int EVENTS_W = 16;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes.
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 96;

    localparam logic [SLOT_W-1:0] MAX_TIMES_RESET = 16'd1024;
    localparam logic [AT_RISK_W-1:0] AT_RISK_MAX = 24'hFFFFFF;
    localparam logic [EVENTS_W-1:0] EVENTS_MAX = 16'hFFFF;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT_FIRST,
        ST_UPDATE,
        ST_CLOSE_LAST,
        ST_EMIT_LAST
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture the incoming record
        logic emit;         // load one result into the output register
        logic final_result; // tlast value of the result being emitted
        logic close_group;  // clear the open group
        logic inc_emitted;  // count one more emitted event time
        logic update;       // add the captured record to the tally
        logic clear_all;    // return all tally state to reset values
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;     // fewer event times emitted than the limit
        logic differ;     // a group is open and the record time differs from it
        logic has_event;  // the open group holds an event
        logic rec_last;   // captured record is the last of the data set
        logic out_free;   // output register can take a result this cycle
        logic arm_last;   // arm counter is at the highest arm
        logic more_after; // a second close of this record will also emit
    } status_t;

endpackage

>>> sv/risk_set_tally_by_arm.sv
// Top level of the risk-set tally by arm: joins the controller and datapath.
// Depends on rstba_pkg, rstba_ctrl and rstba_dp.

// Records are taken one at a time, in non-increasing time order. A record
// passes through accept, check and update; a group close that emits adds
// one emit step per arm, ARMS results in all, and the last record of a
// data set adds a close step, plus ARMS more results if its group emits.
// The single output register takes one result per cycle while the
// downstream side is ready. Once max_times event times have been emitted
// further records are dropped until one marked last clears the tally;
// max_times is kept.
module risk_set_tally_by_arm
    import rstba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // s_tdata: record_time[31:0], event_count[39:32], arm[43:40], zero pad
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    // m_tdata: group_time[31:0], slot[47:32], result_arm[51:48],
    //          at_risk[75:52], group_events[91:76], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    // max_times register write
    input  logic                  cfg_we,
    input  logic [SLOT_W-1:0]     cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    // Sequencing of each transaction.
    rstba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Tallies, limit and output register.
    rstba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> sv/rstba_ctrl.sv
// Controller state machine for the risk-set tally by arm.
// Depends on rstba_pkg; drives the datapath commands from its status.
module rstba_ctrl
    import rstba_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!status.active)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.differ && status.has_event)
                begin
                    state_next = ST_EMIT_FIRST;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_EMIT_FIRST:
            begin
                if (status.out_free && status.arm_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.active && status.rec_last)
                begin
                    state_next = ST_CLOSE_LAST;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLOSE_LAST:
            begin
                if (status.has_event)
                begin
                    state_next = ST_EMIT_LAST;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_LAST:
            begin
                if (status.out_free && status.arm_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        s_tready = 1'b0;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CHECK:
            begin
                if (!status.active)
                begin
                    cmd.clear_all = status.rec_last;
                end
                else if (status.differ && !status.has_event)
                begin
                    cmd.close_group = 1'b1;
                end
            end
            ST_EMIT_FIRST:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.final_result = status.arm_last && !status.more_after;
                    cmd.close_group = status.arm_last;
                    cmd.inc_emitted = status.arm_last;
                end
            end
            ST_UPDATE:
            begin
                if (status.active)
                begin
                    cmd.update = 1'b1;
                end
                else
                begin
                    cmd.clear_all = status.rec_last;
                end
            end
            ST_CLOSE_LAST:
            begin
                cmd.clear_all = !status.has_event;
            end
            ST_EMIT_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.final_result = status.arm_last;
                    cmd.clear_all = status.arm_last;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/rstba_dp.sv
// Datapath for the risk-set tally by arm: per-arm counters, group state,
// limit register and output register. Depends on rstba_pkg.
module rstba_dp
    import rstba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [SLOT_W-1:0]     cfg_wdata,
    input  cmd_t                  cmd,
    output status_t               status
);

    // Per-arm tallies.
    logic [AT_RISK_W-1:0] at_risk_reg  [ARMS];
    logic [AT_RISK_W-1:0] at_risk_next [ARMS];
    logic [EVENTS_W-1:0]  events_reg   [ARMS];
    logic [EVENTS_W-1:0]  events_next  [ARMS];

    // Group and limit state.
    logic [TIME_W-1:0]    open_time_reg, open_time_next;
    logic                 open_reg, open_next;
    logic                 has_event_reg, has_event_next;
    logic [SLOT_W-1:0]    emitted_reg, emitted_next;
    logic [SLOT_W-1:0]    max_times_reg;
    logic [ARM_IDX_W-1:0] idx_reg, idx_next;

    // Captured record.
    logic [TIME_W-1:0]    rec_time_reg;
    logic [EVCNT_W-1:0]   rec_ev_reg;
    logic [ARM_W-1:0]     rec_arm_reg;
    logic                 rec_last_reg;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    logic                  arm_ok;
    logic                  arm_last;
    logic [SLOT_W-1:0]     slot;
    logic [ARM_W-1:0]      result_arm;
    logic [AT_RISK_W-1:0]  sel_at_risk;
    logic [EVENTS_W-1:0]   sel_events;
    logic [EVENTS_W:0]     ev_sum [ARMS];

    assign arm_ok = ({1'b0, rec_arm_reg} < (ARM_W + 1)'(ARMS));
    assign arm_last = (idx_reg == ARM_IDX_W'(ARMS - 1));
    assign slot = max_times_reg - SLOT_W'(1) - emitted_reg;
    assign result_arm = ARM_W'(idx_reg);
    assign sel_at_risk = at_risk_reg[idx_reg];
    assign sel_events = events_reg[idx_reg];

    // Status towards the controller.
    always_comb
    begin
        status.active = (emitted_reg < max_times_reg);
        status.differ = open_reg && (rec_time_reg != open_time_reg);
        status.has_event = has_event_reg;
        status.rec_last = rec_last_reg;
        status.out_free = !out_valid_reg || m_tready;
        status.arm_last = arm_last;
        status.more_after = rec_last_reg && (rec_ev_reg != '0)
            && (({1'b0, emitted_reg} + (SLOT_W + 1)'(1)) < {1'b0, max_times_reg});
    end

    // Per-arm counter lanes, each with its own saturating update.
    always_comb
    begin
        for (int a = 0; a < ARMS; a++)
        begin
            ev_sum[a] = {1'b0, events_reg[a]} + (EVENTS_W + 1)'(rec_ev_reg);
            at_risk_next[a] = at_risk_reg[a];
            events_next[a] = events_reg[a];
            if (cmd.update && arm_ok && (rec_arm_reg == ARM_W'(a)))
            begin
                if (at_risk_reg[a] != AT_RISK_MAX)
                begin
                    at_risk_next[a] = at_risk_reg[a] + AT_RISK_W'(1);
                end
                events_next[a] = ev_sum[a][EVENTS_W] ? EVENTS_MAX
                                                     : ev_sum[a][EVENTS_W-1:0];
            end
            if (cmd.close_group)
            begin
                events_next[a] = '0;
            end
            if (cmd.clear_all)
            begin
                at_risk_next[a] = '0;
                events_next[a] = '0;
            end
        end
    end

    // Group state, emitted count and arm counter.
    always_comb
    begin
        open_time_next = open_time_reg;
        open_next = open_reg;
        has_event_next = has_event_reg;
        emitted_next = emitted_reg;
        idx_next = idx_reg;
        if (cmd.update)
        begin
            open_next = 1'b1;
            open_time_next = rec_time_reg;
            has_event_next = has_event_reg || (rec_ev_reg != '0);
        end
        if (cmd.close_group)
        begin
            open_next = 1'b0;
            has_event_next = 1'b0;
        end
        if (cmd.inc_emitted)
        begin
            emitted_next = emitted_reg + SLOT_W'(1);
        end
        if (cmd.emit)
        begin
            idx_next = arm_last ? '0 : idx_reg + ARM_IDX_W'(1);
        end
        if (cmd.clear_all)
        begin
            open_time_next = '0;
            open_next = 1'b0;
            has_event_next = 1'b0;
            emitted_next = '0;
            idx_next = '0;
        end
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and tally registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < ARMS; a++)
            begin
                at_risk_reg[a] <= '0;
                events_reg[a] <= '0;
            end
            open_time_reg <= '0;
            open_reg <= 1'b0;
            has_event_reg <= 1'b0;
            emitted_reg <= '0;
            max_times_reg <= MAX_TIMES_RESET;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int a = 0; a < ARMS; a++)
            begin
                at_risk_reg[a] <= at_risk_next[a];
                events_reg[a] <= events_next[a];
            end
            open_time_reg <= open_time_next;
            open_reg <= open_next;
            has_event_reg <= has_event_next;
            emitted_reg <= emitted_next;
            if (cfg_we)
            begin
                max_times_reg <= cfg_wdata;
            end
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Record capture and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rec_time_reg <= s_tdata[TIME_W-1:0];
            rec_ev_reg <= s_tdata[TIME_W+EVCNT_W-1:TIME_W];
            rec_arm_reg <= s_tdata[TIME_W+EVCNT_W+ARM_W-1:TIME_W+EVCNT_W];
            rec_last_reg <= s_tlast;
        end
        if (cmd.emit)
        begin
            out_data_reg <= {4'b0, sel_events, sel_at_risk, result_arm, slot, open_time_reg};
            out_last_reg <= cmd.final_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tlast = out_last_reg;

endmodule
